### rtl/core/ffa_pkg.sv
package ffa_pkg;

    localparam int unsigned DEF_MAX_REGIONS = 256;
    localparam logic [31:0] PAGE_ADD        = 32'h0000_0fff;
    localparam logic [31:0] PAGE_MASK       = 32'hffff_f000;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_LOST  = 2'd2;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_QUERY,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] addr;
        logic [31:0] size;
    } t_req;

    typedef struct packed {
        logic valid;
        t_req req;
    } t_qpush;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARD,
        S_ACHK,
        S_FRD,
        S_FCHK,
        S_FDEC,
        S_RMRD,
        S_RMWR,
        S_INRD,
        S_INWR,
        S_RESP
    } t_bstate;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hffff_ffff : s[31:0];
    endfunction

endpackage

### rtl/core/ffa_front.sv
module ffa_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_mode,
    input  logic [31:0]          i_region_address,
    input  logic [31:0]          i_region_size,
    input  logic                 i_round_to_page,
    input  logic                 i_q_full,
    output ffa_pkg::t_qpush      o_push
);
    import ffa_pkg::*;

    logic        r_valid;
    t_req        r_req;
    logic        n_valid;
    t_req        n_req;
    logic        accept;
    logic        push;
    logic [31:0] rounded;

    assign o_stall = r_valid && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign push    = r_valid && !i_q_full;
    assign rounded = (i_region_size + PAGE_ADD) & PAGE_MASK;

    always_comb begin
        n_valid = r_valid;
        n_req   = r_req;
        if (push) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid    = 1'b1;
            n_req.addr = i_region_address;
            n_req.size = i_region_size;
            unique case (i_mode)
                MODE_ALLOC: n_req.op = OP_ALLOC;
                MODE_FREE:  n_req.op = OP_FREE;
                MODE_QUERY: n_req.op = OP_QUERY;
                default:    n_req.op = OP_CLEAR;
            endcase
            if (i_round_to_page && (i_mode == MODE_ALLOC || i_mode == MODE_FREE)) begin
                n_req.size = rounded;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_req <= n_req;
    end

    assign o_push.valid = push;
    assign o_push.req   = r_req;

endmodule

### rtl/core/ffa_queue.sv
module ffa_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ffa_pkg::t_qpush   i_push,
    output logic              o_full,
    output logic              o_valid,
    output ffa_pkg::t_req     o_req,
    input  logic              i_pop
);
    import ffa_pkg::*;

    t_req       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_mem[r_rp];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
        if (do_push) begin
            r_mem[r_wp] <= i_push.req;
        end
    end

endmodule

### rtl/core/ffa_back.sv
module ffa_back #(
    parameter int unsigned MAX_REGIONS = ffa_pkg::DEF_MAX_REGIONS,
    parameter int unsigned CNT_W       = $clog2(MAX_REGIONS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  ffa_pkg::t_req     i_q_req,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [31:0]       o_granted_address,
    output logic [1:0]        o_status,
    output logic [31:0]       o_total_free_bytes,
    output logic [CNT_W-1:0]  o_entries_used,
    output logic [CNT_W-1:0]  o_peak_entries,
    output logic [31:0]       o_lost_bytes,
    output logic [31:0]       o_lost_events
);
    import ffa_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_REGIONS);
    localparam int unsigned SUM_W = 32 + CNT_W;

    logic [31:0] r_mem_s [MAX_REGIONS];
    logic [31:0] r_mem_l [MAX_REGIONS];
    logic [31:0] r_rd_s;
    logic [31:0] r_rd_l;
    logic             we;
    logic [IDX_W-1:0] wa;
    logic [31:0]      wd_s;
    logic [31:0]      wd_l;
    logic [IDX_W-1:0] ra;

    t_bstate          r_state, n_state;
    t_req             r_req, n_req;
    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_peak, n_peak;
    logic [31:0]      r_drop_b, n_drop_b;
    logic [31:0]      r_drop_n, n_drop_n;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [31:0]      r_gaddr, n_gaddr;
    logic [1:0]       r_st, n_st;
    logic             r_pv, n_pv;
    logic [31:0]      r_ps, n_ps;
    logic [31:0]      r_pl, n_pl;
    logic             r_nv, n_nv;
    logic [31:0]      r_ns, n_ns;
    logic [31:0]      r_nl, n_nl;
    logic             r_ov, n_ov;

    logic [CNT_W-1:0] k_inc;
    logic [CNT_W-1:0] k_dec;
    logic [CNT_W-1:0] j_dec;
    logic [CNT_W-1:0] cnt_inc;
    logic             prev_adj;
    logic             next_adj;
    logic [31:0]      merge_l;
    logic [31:0]      merge2_l;

    assign k_inc    = r_k + CNT_W'(1);
    assign k_dec    = r_k - CNT_W'(1);
    assign j_dec    = r_j - CNT_W'(1);
    assign cnt_inc  = r_count + CNT_W'(1);
    assign prev_adj = r_pv && ((r_ps + r_pl) == r_req.addr);
    assign next_adj = r_nv && ((r_req.addr + r_req.size) == r_ns);
    assign merge_l  = sat_add32(r_pl, r_req.size);
    assign merge2_l = next_adj ? sat_add32(merge_l, r_nl) : merge_l;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem_s[wa] <= wd_s;
            r_mem_l[wa] <= wd_l;
        end
        r_rd_s <= r_mem_s[ra];
        r_rd_l <= r_mem_l[ra];
    end

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_k      = r_k;
        n_j      = r_j;
        n_count  = r_count;
        n_peak   = r_peak;
        n_drop_b = r_drop_b;
        n_drop_n = r_drop_n;
        n_sum    = r_sum;
        n_gaddr  = r_gaddr;
        n_st     = r_st;
        n_pv     = r_pv;
        n_ps     = r_ps;
        n_pl     = r_pl;
        n_nv     = r_nv;
        n_ns     = r_ns;
        n_nl     = r_nl;
        n_ov     = r_ov;
        o_q_pop  = 1'b0;
        we       = 1'b0;
        wa       = r_k[IDX_W-1:0];
        wd_s     = r_rd_s;
        wd_l     = r_rd_l;
        ra       = r_k[IDX_W-1:0];

        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_req   = i_q_req;
                    n_gaddr = '0;
                    n_st    = ST_OK;
                    n_k     = '0;
                    n_pv    = 1'b0;
                    n_nv    = 1'b0;
                    unique case (i_q_req.op)
                        OP_ALLOC: begin
                            if (r_count == '0) begin
                                n_st    = ST_NOFIT;
                                n_state = S_RESP;
                            end else begin
                                n_state = S_ARD;
                            end
                        end
                        OP_FREE: begin
                            n_state = (r_count == '0) ? S_FDEC : S_FRD;
                        end
                        OP_QUERY: n_state = S_RESP;
                        default: begin
                            n_count  = '0;
                            n_peak   = '0;
                            n_drop_b = '0;
                            n_drop_n = '0;
                            n_sum    = '0;
                            n_state  = S_RESP;
                        end
                    endcase
                end
            end
            S_ARD: begin
                n_state = S_ACHK;
            end
            S_ACHK: begin
                if (r_rd_l >= r_req.size) begin
                    n_gaddr = r_rd_s;
                    we      = 1'b1;
                    wd_s    = r_rd_s + r_req.size;
                    wd_l    = r_rd_l - r_req.size;
                    n_sum   = r_sum - SUM_W'(r_req.size);
                    n_state = (r_rd_l == r_req.size) ? S_RMRD : S_RESP;
                end else begin
                    n_k = k_inc;
                    if (k_inc == r_count) begin
                        n_st    = ST_NOFIT;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_ARD;
                    end
                end
            end
            S_FRD: begin
                n_state = S_FCHK;
            end
            S_FCHK: begin
                if (r_rd_s > r_req.addr) begin
                    n_nv    = 1'b1;
                    n_ns    = r_rd_s;
                    n_nl    = r_rd_l;
                    n_state = S_FDEC;
                end else begin
                    n_pv = 1'b1;
                    n_ps = r_rd_s;
                    n_pl = r_rd_l;
                    n_k  = k_inc;
                    n_state = (k_inc == r_count) ? S_FDEC : S_FRD;
                end
            end
            S_FDEC: begin
                if (prev_adj) begin
                    we      = 1'b1;
                    wa      = k_dec[IDX_W-1:0];
                    wd_s    = r_ps;
                    wd_l    = merge2_l;
                    n_sum   = r_sum - SUM_W'(r_pl) - (next_adj ? SUM_W'(r_nl) : '0)
                              + SUM_W'(merge2_l);
                    n_state = next_adj ? S_RMRD : S_RESP;
                end else if (next_adj) begin
                    we      = 1'b1;
                    wd_s    = r_req.addr;
                    wd_l    = sat_add32(r_nl, r_req.size);
                    n_sum   = r_sum - SUM_W'(r_nl) + SUM_W'(sat_add32(r_nl, r_req.size));
                    n_state = S_RESP;
                end else if (r_count < CNT_W'(MAX_REGIONS)) begin
                    n_j     = r_count;
                    n_state = S_INRD;
                end else begin
                    n_drop_b = sat_add32(r_drop_b, r_req.size);
                    if (r_drop_n != 32'hffff_ffff) begin
                        n_drop_n = r_drop_n + 32'd1;
                    end
                    n_st    = ST_LOST;
                    n_state = S_RESP;
                end
            end
            S_RMRD: begin
                if (k_inc < r_count) begin
                    ra      = k_inc[IDX_W-1:0];
                    n_state = S_RMWR;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_RESP;
                end
            end
            S_RMWR: begin
                we      = 1'b1;
                n_k     = k_inc;
                n_state = S_RMRD;
            end
            S_INRD: begin
                if (r_j > r_k) begin
                    ra      = j_dec[IDX_W-1:0];
                    n_state = S_INWR;
                end else begin
                    we      = 1'b1;
                    wd_s    = r_req.addr;
                    wd_l    = r_req.size;
                    n_count = cnt_inc;
                    if (r_peak < cnt_inc) begin
                        n_peak = cnt_inc;
                    end
                    n_sum   = r_sum + SUM_W'(r_req.size);
                    n_state = S_RESP;
                end
            end
            S_INWR: begin
                we      = 1'b1;
                wa      = r_j[IDX_W-1:0];
                n_j     = j_dec;
                n_state = S_INRD;
            end
            S_RESP: begin
                if (!r_ov || !i_stall) begin
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_peak   <= '0;
            r_drop_b <= '0;
            r_drop_n <= '0;
            r_sum    <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_peak   <= n_peak;
            r_drop_b <= n_drop_b;
            r_drop_n <= n_drop_n;
            r_sum    <= n_sum;
            r_ov     <= n_ov;
        end
        r_req   <= n_req;
        r_k     <= n_k;
        r_j     <= n_j;
        r_gaddr <= n_gaddr;
        r_st    <= n_st;
        r_pv    <= n_pv;
        r_ps    <= n_ps;
        r_pl    <= n_pl;
        r_nv    <= n_nv;
        r_ns    <= n_ns;
        r_nl    <= n_nl;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RESP && (!r_ov || !i_stall)) begin
            o_granted_address  <= r_gaddr;
            o_status           <= r_st;
            o_total_free_bytes <= (r_sum[SUM_W-1:32] != '0) ? 32'hffff_ffff : r_sum[31:0];
            o_entries_used     <= r_count;
            o_peak_entries     <= r_peak;
            o_lost_bytes       <= r_drop_b;
            o_lost_events      <= r_drop_n;
        end
    end

    assign o_valid = r_ov;

endmodule

### rtl/core/first_fit_free_list_allocator.sv
// Channel   Handshake            Payload
// request   i_valid / o_stall    i_mode, i_region_address, i_region_size, i_round_to_page
// result    o_valid / i_stall    o_granted_address, o_status, o_total_free_bytes,
//                                o_entries_used, o_peak_entries, o_lost_bytes, o_lost_events
// One request at a time in the back end; each table entry scanned takes a read state and a
// check state, each entry shifted takes a read state and a write state, and a shift starts
// where the scan stopped. The region table has one read port and one write port a cycle.
// Reset empties the table at once; no clearing pass.
// Up to three requests wait ahead of the back end, one in the front register and two in
// the queue; a stalled result holds the back end only.
module first_fit_free_list_allocator #(
    parameter int unsigned MAX_REGIONS = ffa_pkg::DEF_MAX_REGIONS,
    parameter int unsigned CNT_W       = $clog2(MAX_REGIONS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_mode,
    input  logic [31:0]       i_region_address,
    input  logic [31:0]       i_region_size,
    input  logic              i_round_to_page,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [31:0]       o_granted_address,
    output logic [1:0]        o_status,
    output logic [31:0]       o_total_free_bytes,
    output logic [CNT_W-1:0]  o_entries_used,
    output logic [CNT_W-1:0]  o_peak_entries,
    output logic [31:0]       o_lost_bytes,
    output logic [31:0]       o_lost_events
);
    import ffa_pkg::*;

    t_qpush q_push;
    logic   q_full;
    logic   q_valid;
    t_req   q_req;
    logic   q_pop;

    ffa_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_region_address (i_region_address),
        .i_region_size    (i_region_size),
        .i_round_to_page  (i_round_to_page),
        .i_q_full         (q_full),
        .o_push           (q_push)
    );

    ffa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_req   (q_req),
        .i_pop   (q_pop)
    );

    ffa_back #(
        .MAX_REGIONS (MAX_REGIONS),
        .CNT_W       (CNT_W)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_q_req            (q_req),
        .o_q_pop            (q_pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_granted_address  (o_granted_address),
        .o_status           (o_status),
        .o_total_free_bytes (o_total_free_bytes),
        .o_entries_used     (o_entries_used),
        .o_peak_entries     (o_peak_entries),
        .o_lost_bytes       (o_lost_bytes),
        .o_lost_events      (o_lost_events)
    );

endmodule

### rtl/core/ffa_checker.sv
module ffa_checker #(
    parameter int unsigned MAX_REGIONS = ffa_pkg::DEF_MAX_REGIONS,
    parameter int unsigned CNT_W       = $clog2(MAX_REGIONS + 1)
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic [31:0]       o_granted_address,
    input logic [1:0]        o_status,
    input logic [CNT_W-1:0]  o_entries_used,
    input logic [CNT_W-1:0]  o_peak_entries
);
    import ffa_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entries_used <= o_peak_entries)
        else $error("peak below current count");

    a_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_LOST |-> o_entries_used == CNT_W'(MAX_REGIONS))
        else $error("region lost with room in table");

    a_nofit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_NOFIT |-> o_granted_address == 32'd0)
        else $error("address granted without fit");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == ST_OK || o_status == ST_NOFIT || o_status == ST_LOST)
        else $error("undefined status");

endmodule

bind first_fit_free_list_allocator ffa_checker #(
    .MAX_REGIONS (MAX_REGIONS),
    .CNT_W       (CNT_W)
) u_ffa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_granted_address (o_granted_address),
    .o_status          (o_status),
    .o_entries_used    (o_entries_used),
    .o_peak_entries    (o_peak_entries)
);
